@@ sv/trp_pkg.sv @@
package trp_pkg;

  localparam int ARROW_W   = 3;
  localparam int PROX_W    = 8;
  localparam int PAD_W     = 12;
  localparam int PAD_X_MAX = 2328;
  localparam int PAD_Y_MAX = 1691;

  localparam int SCREEN_W_DEF = 320;
  localparam int SCREEN_H_DEF = 240;

  typedef logic [ARROW_W-1:0] arrow_t;

  // arrow codes, also used as button codes
  localparam arrow_t ARROW_NONE  = 3'd0;
  localparam arrow_t ARROW_CLICK = 3'd1;
  localparam arrow_t ARROW_LEFT  = 3'd2;
  localparam arrow_t ARROW_RIGHT = 3'd3;
  localparam arrow_t ARROW_UP    = 3'd4;
  localparam arrow_t ARROW_DOWN  = 3'd5;

  localparam arrow_t BTN_NONE = ARROW_NONE;

  typedef struct packed {
    arrow_t arrow;
    logic   near;
  } trp_ctl_t;

endpackage

@@ sv/trp_in_if.sv @@
interface trp_in_if;
  logic                        valid;
  logic                        ready;
  logic [trp_pkg::ARROW_W-1:0] arrow;
  logic [trp_pkg::PROX_W-1:0]  proximity;
  logic                        pressed;
  logic [trp_pkg::PAD_W-1:0]   pad_x;
  logic [trp_pkg::PAD_W-1:0]   pad_y;

  modport source (output valid, arrow, proximity, pressed, pad_x, pad_y, input ready);
  modport sink (input valid, arrow, proximity, pressed, pad_x, pad_y, output ready);
endinterface

@@ sv/trp_out_if.sv @@
interface trp_out_if #(
  parameter int XW = $clog2(trp_pkg::SCREEN_W_DEF + 1),
  parameter int YW = $clog2(trp_pkg::SCREEN_H_DEF + 1)
);
  logic                        valid;
  logic                        ready;
  logic                        changed;
  logic [XW-1:0]               cursor_x;
  logic [YW-1:0]               cursor_y;
  logic [trp_pkg::ARROW_W-1:0] released_button;

  modport source (output valid, changed, cursor_x, cursor_y, released_button, input ready);
  modport sink (input valid, changed, cursor_x, cursor_y, released_button, output ready);
endinterface

@@ sv/trp_scale.sv @@
module trp_scale #(
  parameter int SCREEN_W = trp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = trp_pkg::SCREEN_H_DEF,
  localparam int XW = $clog2(SCREEN_W + 1),
  localparam int YW = $clog2(SCREEN_H + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  trp_in_if.sink            in_ch,
  output logic              sc_vld,
  output trp_pkg::trp_ctl_t sc_ctl,
  output logic [XW-1:0]     sc_x,
  output logic [YW-1:0]     sc_y,
  input  logic              sc_rdy
);

  localparam int PXW = $clog2(trp_pkg::PAD_X_MAX + 1);
  localparam int PYW = $clog2(trp_pkg::PAD_Y_MAX + 1);
  // product widths and exact reciprocal shifts
  localparam int NX  = PXW + XW;
  localparam int NY  = PYW + YW;
  localparam int SHX = NX + $clog2(trp_pkg::PAD_X_MAX);
  localparam int SHY = NY + $clog2(trp_pkg::PAD_Y_MAX);
  localparam int MXW = NX + 1;
  localparam int MYW = NY + 1;
  localparam logic [MXW-1:0] RECIP_X = MXW'(((64'd1 << SHX) + 64'(trp_pkg::PAD_X_MAX) - 64'd1)
                                            / 64'(trp_pkg::PAD_X_MAX));
  localparam logic [MYW-1:0] RECIP_Y = MYW'(((64'd1 << SHY) + 64'(trp_pkg::PAD_Y_MAX) - 64'd1)
                                            / 64'(trp_pkg::PAD_Y_MAX));
  localparam logic [trp_pkg::PAD_W-1:0] PX_MAX = trp_pkg::PAD_W'(trp_pkg::PAD_X_MAX);
  localparam logic [trp_pkg::PAD_W-1:0] PY_MAX = trp_pkg::PAD_W'(trp_pkg::PAD_Y_MAX);

  logic              en_a, en_b, en_c;
  logic              a_vld_r, b_vld_r, c_vld_r;
  trp_pkg::trp_ctl_t a_ctl_r, b_ctl_r, c_ctl_r, a_ctl_nxt;
  logic [PXW-1:0]    a_px_r, a_px_nxt;
  logic [PYW-1:0]    a_py_r, a_py_nxt;
  logic [NX-1:0]     b_prod_x_r, b_prod_x_nxt;
  logic [NY-1:0]     b_prod_y_r, b_prod_y_nxt;
  logic [NX+MXW-1:0] qx_full;
  logic [NY+MYW-1:0] qy_full;
  logic [XW-1:0]     c_sx_r;
  logic [YW-1:0]     c_sy_r;

  assign en_c = !c_vld_r || sc_rdy;
  assign en_b = !b_vld_r || en_c;
  assign en_a = !a_vld_r || en_b;
  assign in_ch.ready = en_a;

  always_comb begin
    a_ctl_nxt.arrow = in_ch.arrow;
    a_ctl_nxt.near  = (in_ch.proximity != '0) && !in_ch.pressed;
    a_px_nxt = (in_ch.pad_x > PX_MAX) ? PXW'(trp_pkg::PAD_X_MAX) : PXW'(in_ch.pad_x);
    // y inverted, pad y above the limit lands on zero
    a_py_nxt = (in_ch.pad_y > PY_MAX) ? '0 : PYW'(PY_MAX - in_ch.pad_y);
  end

  assign b_prod_x_nxt = NX'(a_px_r) * NX'(SCREEN_W);
  assign b_prod_y_nxt = NY'(a_py_r) * NY'(SCREEN_H);
  assign qx_full = (NX+MXW)'(b_prod_x_r) * (NX+MXW)'(RECIP_X);
  assign qy_full = (NY+MYW)'(b_prod_y_r) * (NY+MYW)'(RECIP_Y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (en_a) a_vld_r <= in_ch.valid;
      if (en_b) b_vld_r <= a_vld_r;
      if (en_c) c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_ctl_r <= a_ctl_nxt;
      a_px_r  <= a_px_nxt;
      a_py_r  <= a_py_nxt;
    end
    if (en_b) begin
      b_ctl_r    <= a_ctl_r;
      b_prod_x_r <= b_prod_x_nxt;
      b_prod_y_r <= b_prod_y_nxt;
    end
    if (en_c) begin
      c_ctl_r <= b_ctl_r;
      c_sx_r  <= qx_full[SHX +: XW];
      c_sy_r  <= qy_full[SHY +: YW];
    end
  end

  assign sc_vld = c_vld_r;
  assign sc_ctl = c_ctl_r;
  assign sc_x   = c_sx_r;
  assign sc_y   = c_sy_r;

endmodule

@@ sv/trp_track.sv @@
module trp_track #(
  parameter int SCREEN_W = trp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = trp_pkg::SCREEN_H_DEF,
  localparam int XW = $clog2(SCREEN_W + 1),
  localparam int YW = $clog2(SCREEN_H + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pad_en,
  input  logic              sc_vld,
  input  trp_pkg::trp_ctl_t sc_ctl,
  input  logic [XW-1:0]     sc_x,
  input  logic [YW-1:0]     sc_y,
  output logic              sc_rdy,
  trp_out_if.source         out_ch
);

  localparam logic [XW-1:0] CUR_X_RST = XW'(SCREEN_W / 2);
  localparam logic [YW-1:0] CUR_Y_RST = YW'(SCREEN_H / 2);
  localparam logic signed [XW+1:0] X_HI = (XW+2)'(SCREEN_W);
  localparam logic signed [YW+1:0] Y_HI = (YW+2)'(SCREEN_H);

  logic                   take;
  logic                   out_vld_r;
  logic                   chg_r, chg_nxt;
  trp_pkg::arrow_t        rel_r, rel_nxt;
  trp_pkg::arrow_t        pend_r, pend_nxt;
  logic [XW-1:0]          cur_x_r, cur_x_nxt, anc_x_r, anc_x_nxt, clamp_x;
  logic [YW-1:0]          cur_y_r, cur_y_nxt, anc_y_r, anc_y_nxt, clamp_y;
  logic                   anc_vld_r, anc_vld_nxt;
  logic signed [XW+1:0]   nx;
  logic signed [YW+1:0]   ny;

  assign sc_rdy = !out_vld_r || out_ch.ready;
  assign take   = sc_vld && sc_rdy;

  assign nx = signed'({2'b00, cur_x_r}) + signed'({2'b00, sc_x}) - signed'({2'b00, anc_x_r});
  assign ny = signed'({2'b00, cur_y_r}) + signed'({2'b00, sc_y}) - signed'({2'b00, anc_y_r});

  always_comb begin
    if (nx < 0) begin
      clamp_x = '0;
    end else if (nx > X_HI) begin
      clamp_x = XW'(SCREEN_W);
    end else begin
      clamp_x = XW'(nx);
    end
    if (ny < 0) begin
      clamp_y = '0;
    end else if (ny > Y_HI) begin
      clamp_y = YW'(SCREEN_H);
    end else begin
      clamp_y = YW'(ny);
    end
  end

  always_comb begin
    chg_nxt     = 1'b0;
    rel_nxt     = trp_pkg::BTN_NONE;
    pend_nxt    = pend_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    anc_x_nxt   = anc_x_r;
    anc_y_nxt   = anc_y_r;
    anc_vld_nxt = anc_vld_r;
    if (pad_en) begin
      if (pend_r != trp_pkg::BTN_NONE) begin
        // release only once the arrow goes back to none
        if (sc_ctl.arrow == trp_pkg::ARROW_NONE) begin
          rel_nxt  = pend_r;
          pend_nxt = trp_pkg::BTN_NONE;
          chg_nxt  = 1'b1;
        end
      end else begin
        unique case (sc_ctl.arrow) inside
          trp_pkg::ARROW_CLICK, trp_pkg::ARROW_LEFT, trp_pkg::ARROW_RIGHT,
          trp_pkg::ARROW_UP, trp_pkg::ARROW_DOWN: begin
            pend_nxt = sc_ctl.arrow;
          end
          default: begin
            if (sc_ctl.near) begin
              if (anc_vld_r) begin
                cur_x_nxt = clamp_x;
                cur_y_nxt = clamp_y;
                chg_nxt   = 1'b1;
              end
              anc_x_nxt   = sc_x;
              anc_y_nxt   = sc_y;
              anc_vld_nxt = 1'b1;
            end else begin
              anc_x_nxt   = '0;
              anc_y_nxt   = '0;
              anc_vld_nxt = 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      pend_r    <= trp_pkg::BTN_NONE;
      cur_x_r   <= CUR_X_RST;
      cur_y_r   <= CUR_Y_RST;
      anc_x_r   <= '0;
      anc_y_r   <= '0;
      anc_vld_r <= 1'b0;
    end else begin
      if (sc_rdy) out_vld_r <= sc_vld;
      if (take) begin
        pend_r    <= pend_nxt;
        cur_x_r   <= cur_x_nxt;
        cur_y_r   <= cur_y_nxt;
        anc_x_r   <= anc_x_nxt;
        anc_y_r   <= anc_y_nxt;
        anc_vld_r <= anc_vld_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      chg_r <= chg_nxt;
      rel_r <= rel_nxt;
    end
  end

  // cursor state only moves when the next item is taken, so it matches the held result
  assign out_ch.valid           = out_vld_r;
  assign out_ch.changed         = chg_r;
  assign out_ch.cursor_x        = cur_x_r;
  assign out_ch.cursor_y        = cur_y_r;
  assign out_ch.released_button = rel_r;

endmodule

@@ sv/touchpad_relative_pointer_top.sv @@
// channel   direction  handshake      payload
// in_ch     input      valid/ready    arrow, proximity, pressed, pad_x, pad_y
// out_ch    output     valid/ready    changed, cursor_x, cursor_y, released_button
// cfg_*     input      cfg_we         cfg_wdata = pad_enable
//
// one item per cycle sustained while out_ch.ready holds; an accepted item is registered
// in order through the input register, scale multiply, reciprocal multiply, cursor update
// two of these stages are multipliers; the cursor update is a single step
// rst_n is synchronous: cursor to screen center, no anchor, no pending button,
// pad_enable set; a stalled result holds while the earlier stages keep filling
module touchpad_relative_pointer_top #(
  parameter int SCREEN_W = trp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = trp_pkg::SCREEN_H_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  trp_in_if.sink    in_ch,
  trp_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int XW = $clog2(SCREEN_W + 1);
  localparam int YW = $clog2(SCREEN_H + 1);

  logic              pad_en_r;
  logic              sc_vld, sc_rdy;
  trp_pkg::trp_ctl_t sc_ctl;
  logic [XW-1:0]     sc_x;
  logic [YW-1:0]     sc_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_en_r <= 1'b1;
    end else if (cfg_we) begin
      pad_en_r <= cfg_wdata;
    end
  end

  trp_scale #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .sc_vld (sc_vld),
    .sc_ctl (sc_ctl),
    .sc_x   (sc_x),
    .sc_y   (sc_y),
    .sc_rdy (sc_rdy)
  );

  trp_track #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .pad_en (pad_en_r),
    .sc_vld (sc_vld),
    .sc_ctl (sc_ctl),
    .sc_x   (sc_x),
    .sc_y   (sc_y),
    .sc_rdy (sc_rdy),
    .out_ch (out_ch)
  );

  a_rel_implies_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.released_button != trp_pkg::BTN_NONE) |-> out_ch.changed)
    else $error("release reported without changed");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.cursor_x <= XW'(SCREEN_W)) && (out_ch.cursor_y <= YW'(SCREEN_H)))
    else $error("cursor outside screen");

  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a blocked result");

  a_steady_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> ($stable(out_ch.cursor_x) && $stable(out_ch.cursor_y)))
    else $error("cursor moved while result blocked");

endmodule
